FILE: rtl/core/tvfg_pkg.sv
// shared types, constants and helper functions of the thermal/voltage frequency governor
`default_nettype none

package tvfg_pkg;

  localparam int unsigned TempW  = 8;
  localparam int unsigned FreqW  = 10;
  localparam int unsigned VoltW  = 10;
  localparam int unsigned WaitW  = 3;
  localparam int unsigned VtickW = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InFieldsW  = 1 + TempW + VoltW;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = FreqW + 2;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [FreqW-1:0]  HotDrop  = FreqW'(40);
  localparam logic [FreqW-1:0]  CoolRise = FreqW'(20);
  localparam logic [FreqW-1:0]  SagDrop  = FreqW'(20);
  localparam logic [VtickW-1:0] SagTicks = VtickW'(2);

  localparam logic [TempW-1:0] TempLowRst     = TempW'(60);
  localparam logic [TempW-1:0] TempHighRst    = TempW'(65);
  localparam logic [FreqW-1:0] FreqFloorRst   = FreqW'(100);
  localparam logic [FreqW-1:0] FreqCeilingRst = FreqW'(360);
  localparam logic [VoltW-1:0] VoltLowRst     = VoltW'(450);
  localparam logic [VoltW-1:0] VoltHighRst    = VoltW'(460);
  localparam logic [WaitW-1:0] RiseWaitRst    = WaitW'(1);
  localparam logic [WaitW-1:0] FallWaitRst    = WaitW'(2);
  localparam logic [FreqW-1:0] FreqRst        = FreqW'(360);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_LOW     = 3'd0,
    CFG_TEMP_HIGH    = 3'd1,
    CFG_FREQ_FLOOR   = 3'd2,
    CFG_FREQ_CEILING = 3'd3,
    CFG_VOLT_LOW     = 3'd4,
    CFG_VOLT_HIGH    = 3'd5,
    CFG_RISE_WAIT    = 3'd6,
    CFG_FALL_WAIT    = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    MODE_TEMP = 1'b0,
    MODE_VOLT = 1'b1
  } mode_e;

  typedef struct packed {
    logic [TempW-1:0] temp_low;
    logic [TempW-1:0] temp_high;
    logic [FreqW-1:0] freq_floor;
    logic [FreqW-1:0] freq_ceiling;
    logic [VoltW-1:0] volt_low;
    logic [VoltW-1:0] volt_high;
    logic [WaitW-1:0] rise_wait;
    logic [WaitW-1:0] fall_wait;
  } cfg_t;

  typedef struct packed {
    logic [VoltW-1:0] supply_sample;
    logic [TempW-1:0] temperature;
    logic             power_on;
  } in_item_t;

  typedef struct packed {
    mode_e            volt_mode;
    logic             too_hot;
    logic [FreqW-1:0] freq_target;
  } result_t;

  // subtract with saturation at zero, then lift to the floor
  function automatic logic [FreqW-1:0] sub_floor(input logic [FreqW-1:0] f,
                                                 input logic [FreqW-1:0] d,
                                                 input logic [FreqW-1:0] floor_v);
    logic [FreqW-1:0] r;
    r = (f > d) ? (f - d) : '0;
    if (r < floor_v) begin
      r = floor_v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tvfg_cfg.sv
// configuration register file of the governor
`default_nettype none

module tvfg_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tvfg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tvfg_pkg::CfgDataW-1:0] cfg_data_i,
  output tvfg_pkg::cfg_t                     cfg_o
);
  import tvfg_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TEMP_LOW:     cfg_d.temp_low     = cfg_data_i[TempW-1:0];
        CFG_TEMP_HIGH:    cfg_d.temp_high    = cfg_data_i[TempW-1:0];
        CFG_FREQ_FLOOR:   cfg_d.freq_floor   = cfg_data_i[FreqW-1:0];
        CFG_FREQ_CEILING: cfg_d.freq_ceiling = cfg_data_i[FreqW-1:0];
        CFG_VOLT_LOW:     cfg_d.volt_low     = cfg_data_i[VoltW-1:0];
        CFG_VOLT_HIGH:    cfg_d.volt_high    = cfg_data_i[VoltW-1:0];
        CFG_RISE_WAIT:    cfg_d.rise_wait    = cfg_data_i[WaitW-1:0];
        CFG_FALL_WAIT:    cfg_d.fall_wait    = cfg_data_i[WaitW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_low     <= TempLowRst;
      cfg_q.temp_high    <= TempHighRst;
      cfg_q.freq_floor   <= FreqFloorRst;
      cfg_q.freq_ceiling <= FreqCeilingRst;
      cfg_q.volt_low     <= VoltLowRst;
      cfg_q.volt_high    <= VoltHighRst;
      cfg_q.rise_wait    <= RiseWaitRst;
      cfg_q.fall_wait    <= FallWaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/tvfg_core.sv
// governor state registers and the per-tick update logic
`default_nettype none

module tvfg_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire tvfg_pkg::in_item_t item_i,
  input  wire tvfg_pkg::cfg_t     cfg_i,
  output tvfg_pkg::result_t  result_o
);
  import tvfg_pkg::*;

  mode_e             mode_q, mode_d;
  logic [FreqW-1:0]  freq_q, freq_d;
  logic              hot_q, hot_d;
  logic [WaitW-1:0]  wait_cnt_q, wait_cnt_d;
  logic [VtickW-1:0] vtick_q, vtick_d;
  logic [TempW-1:0]  prev_temp_q, prev_temp_d;

  logic             rising;
  logic [WaitW-1:0] wait_sel;
  logic [FreqW:0]   cool_f;

  always_comb begin
    mode_d      = mode_q;
    freq_d      = freq_q;
    hot_d       = hot_q;
    wait_cnt_d  = wait_cnt_q;
    vtick_d     = vtick_q;
    prev_temp_d = prev_temp_q;

    rising   = prev_temp_q < item_i.temperature;
    wait_sel = rising ? cfg_i.rise_wait : cfg_i.fall_wait;
    cool_f   = {1'b0, freq_q};
    if (freq_q <= cfg_i.freq_ceiling) begin
      cool_f = {1'b0, freq_q} + {1'b0, CoolRise};
    end
    if (cool_f > {1'b0, cfg_i.freq_ceiling}) begin
      cool_f = {1'b0, cfg_i.freq_ceiling};
    end

    if (!item_i.power_on) begin
      if (item_i.temperature < cfg_i.temp_low) begin
        hot_d = 1'b0;
      end
    end else if (mode_q == MODE_TEMP) begin
      if (item_i.supply_sample < cfg_i.volt_low) begin
        wait_cnt_d = '0;
        mode_d     = MODE_VOLT;
      end else if (prev_temp_q == '0) begin
        // while the last temperature is zero, a reading only primes it
        prev_temp_d = item_i.temperature;
      end else begin
        prev_temp_d = item_i.temperature;
        if (wait_cnt_q >= wait_sel) begin
          wait_cnt_d = '0;
          if (item_i.temperature >= cfg_i.temp_high) begin
            if (freq_q > cfg_i.freq_floor) begin
              freq_d = sub_floor(freq_q, HotDrop, cfg_i.freq_floor);
            end else begin
              freq_d = cfg_i.freq_floor;
              hot_d  = 1'b1;
            end
          end else if (item_i.temperature < cfg_i.temp_low) begin
            hot_d  = 1'b0;
            freq_d = cool_f[FreqW-1:0];
          end else begin
            hot_d = 1'b0;
          end
        end else begin
          wait_cnt_d = wait_cnt_q + WaitW'(1);
        end
      end
    end else begin
      if (vtick_q == SagTicks) begin
        if (item_i.supply_sample >= cfg_i.volt_low) begin
          vtick_d = '0;
          if (item_i.supply_sample > cfg_i.volt_high) begin
            mode_d = MODE_TEMP;
          end
        end else begin
          freq_d  = sub_floor(freq_q, SagDrop, cfg_i.freq_floor);
          vtick_d = VtickW'(1);
        end
      end else begin
        vtick_d = vtick_q + VtickW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TEMP;
      freq_q      <= FreqRst;
      hot_q       <= 1'b0;
      wait_cnt_q  <= '0;
      vtick_q     <= '0;
      prev_temp_q <= '0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      freq_q      <= freq_d;
      hot_q       <= hot_d;
      wait_cnt_q  <= wait_cnt_d;
      vtick_q     <= vtick_d;
      prev_temp_q <= prev_temp_d;
    end
  end

  // the state after the last update is the result of that tick
  assign result_o.freq_target = freq_q;
  assign result_o.too_hot     = hot_q;
  assign result_o.volt_mode   = mode_q;

endmodule

`default_nettype wire

FILE: rtl/core/thermal_voltage_freq_governor_top.sv
// top level of the thermal and supply-voltage frequency governor
// Each input transaction is one monitor tick and gives exactly one result transaction
// carrying the new target frequency, the too-hot flag and the mode. The block takes
// one tick per cycle while the result slot is free or being drained: a tick is held in
// an input register, the update logic runs from there into the state registers, and
// those registers are the result held on the output side, so a result passes through
// the input register and then the state registers before it is presented.
// The input register lets a new tick be taken while the previous result is still
// waiting on m_axis_tready.
// Configuration writes take effect on the next clock edge and are meant for idle time.
`default_nettype none

module thermal_voltage_freq_governor_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tvfg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tvfg_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // power_on [0], temperature [8:1], supply_sample [18:9], zero pad above
  input  wire logic [tvfg_pkg::InDataW-1:0]  s_axis_tdata,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // freq_target [9:0], too_hot [10], volt_mode [11], zero pad above
  output      logic [tvfg_pkg::OutDataW-1:0] m_axis_tdata
);
  import tvfg_pkg::*;

  cfg_t     cfg;
  in_item_t item_q;
  result_t  result;
  logic     in_valid_q;
  logic     out_valid_q;
  logic     step;

  tvfg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // update state when a tick is held and the result slot is free or being drained
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= in_item_t'(s_axis_tdata[InFieldsW-1:0]);
    end
  end

  tvfg_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutFieldsW){1'b0}}, result};

endmodule

`default_nettype wire

FILE: tb/thermal_voltage_freq_governor_top_tb.sv
// self-checking stream testbench of the thermal and supply-voltage frequency governor
module thermal_voltage_freq_governor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvfg_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // power_on [0], temperature [8:1], supply_sample [18:9], zero pad above
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // freq_target [9:0], too_hot [10], volt_mode [11], zero pad above
  logic [OutDataW-1:0] m_axis_tdata;

  thermal_voltage_freq_governor_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // governor state as predicted from the accepted ticks
  cfg_t             gov_cfg = '{temp_low: TempLowRst, temp_high: TempHighRst,
                                freq_floor: FreqFloorRst, freq_ceiling: FreqCeilingRst,
                                volt_low: VoltLowRst, volt_high: VoltHighRst,
                                rise_wait: RiseWaitRst, fall_wait: FallWaitRst};
  mode_e            gov_mode      = MODE_TEMP;
  logic [FreqW-1:0] gov_freq      = FreqRst;
  logic             gov_hot       = 1'b0;
  logic [WaitW-1:0] gov_wait_cnt  = '0;
  logic [VtickW-1:0] gov_vtick    = '0;
  logic [TempW-1:0] gov_last_temp = '0;

  result_t expected_results[$];

  int unsigned src_gap_pct    = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned failures       = 0;
  int unsigned n_ticks        = 0;
  int unsigned n_results      = 0;
  int unsigned n_settings     = 0;
  int unsigned stall_cycles   = 0;

  // stimulus shaping state
  int temp_walk = 60;
  bit sagging   = 1'b0;

  function automatic logic [FreqW-1:0] lowered_freq(input logic [FreqW-1:0] f,
                                                    input logic [FreqW-1:0] d);
    logic [FreqW-1:0] r;
    r = (f > d) ? f - d : '0;
    if (r < gov_cfg.freq_floor) r = gov_cfg.freq_floor;
    return r;
  endfunction

  // advance the predicted governor by one tick and return the result it shows
  function automatic result_t governor_step(input in_item_t it);
    result_t          r;
    logic             rising;
    logic [WaitW-1:0] hold;
    logic [FreqW:0]   raised;
    if (!it.power_on) begin
      if (gov_hot && it.temperature < gov_cfg.temp_low) gov_hot = 1'b0;
    end else if (gov_mode == MODE_TEMP) begin
      if (it.supply_sample < gov_cfg.volt_low) begin
        gov_wait_cnt = '0;
        gov_mode     = MODE_VOLT;
      end else if (gov_last_temp == '0) begin
        // no reading taken yet, a zero reading keeps it that way
        gov_last_temp = it.temperature;
      end else begin
        rising        = gov_last_temp < it.temperature;
        gov_last_temp = it.temperature;
        hold          = rising ? gov_cfg.rise_wait : gov_cfg.fall_wait;
        if (gov_wait_cnt < hold) begin
          gov_wait_cnt = gov_wait_cnt + 1'b1;
        end else begin
          gov_wait_cnt = '0;
          if (it.temperature >= gov_cfg.temp_high) begin
            if (gov_freq > gov_cfg.freq_floor) begin
              gov_freq = lowered_freq(gov_freq, FreqW'(40));
            end else begin
              gov_freq = gov_cfg.freq_floor;
              gov_hot  = 1'b1;
            end
          end else if (it.temperature < gov_cfg.temp_low) begin
            gov_hot = 1'b0;
            raised  = {1'b0, gov_freq};
            if (raised <= gov_cfg.freq_ceiling) raised = raised + (FreqW + 1)'(20);
            if (raised > gov_cfg.freq_ceiling) raised = {1'b0, gov_cfg.freq_ceiling};
            gov_freq = raised[FreqW-1:0];
          end else begin
            gov_hot = 1'b0;
          end
        end
      end
    end else begin
      if (gov_vtick == VtickW'(2)) begin
        gov_vtick = '0;
        if (it.supply_sample >= gov_cfg.volt_low) begin
          if (it.supply_sample > gov_cfg.volt_high) gov_mode = MODE_TEMP;
        end else begin
          gov_freq  = lowered_freq(gov_freq, FreqW'(20));
          gov_vtick = VtickW'(1);
        end
      end else begin
        gov_vtick = gov_vtick + 1'b1;
      end
    end
    r.freq_target = gov_freq;
    r.too_hot     = gov_hot;
    r.volt_mode   = gov_mode;
    return r;
  endfunction

  function automatic in_item_t tick_of(input int p, input int t, input int v);
    in_item_t it;
    it.power_on      = p[0];
    it.temperature   = TempW'(t);
    it.supply_sample = VoltW'(v);
    return it;
  endfunction

  // temperature mostly wanders around the thresholds, with jumps now and then
  function automatic logic [TempW-1:0] next_temp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      temp_walk = int'($urandom_range(0, 255));
    end else begin
      if (r < 25) begin
        temp_walk = ($urandom_range(0, 1) ? int'(gov_cfg.temp_low) : int'(gov_cfg.temp_high))
                    + int'($urandom_range(0, 6)) - 3;
      end else begin
        temp_walk = temp_walk + int'($urandom_range(0, 6)) - 3;
      end
      if (temp_walk < 1) temp_walk = 1;
      if (temp_walk > 255) temp_walk = 255;
    end
    return TempW'(temp_walk);
  endfunction

  // supply comes in sag episodes so that voltage mode is entered and left
  function automatic logic [VoltW-1:0] next_supply();
    int unsigned r;
    int          lo;
    int          hi;
    lo = int'(gov_cfg.volt_low);
    hi = int'(gov_cfg.volt_high);
    if ($urandom_range(0, 99) < (sagging ? 12 : 4)) sagging = !sagging;
    r = $urandom_range(0, 99);
    if (r < 10) return VoltW'($urandom_range(0, 1023));
    if (sagging && lo > 0) return VoltW'($urandom_range(0, lo - 1));
    if (r < 30) return VoltW'($urandom_range(lo, hi));
    if (hi < 1023) return VoltW'($urandom_range(hi + 1, 1023));
    return VoltW'(1023);
  endfunction

  function automatic in_item_t random_tick();
    in_item_t it;
    it.power_on      = ($urandom_range(0, 99) < 92);
    it.temperature   = next_temp();
    it.supply_sample = next_supply();
    return it;
  endfunction

  // mostly ordered settings, sometimes with swapped limits
  function automatic cfg_t pick_settings();
    cfg_t c;
    int   tl;
    int   fl;
    int   fc;
    int   vl;
    tl = int'($urandom_range(20, 90));
    fl = int'($urandom_range(0, 400));
    fc = fl + int'($urandom_range(0, 600));
    vl = int'($urandom_range(100, 900));
    c.temp_low     = TempW'(tl);
    c.temp_high    = TempW'(tl + int'($urandom_range(0, 20)));
    c.freq_floor   = FreqW'(fl);
    c.freq_ceiling = FreqW'((fc > 1023) ? 1023 : fc);
    c.volt_low     = VoltW'(vl);
    c.volt_high    = VoltW'(vl + int'($urandom_range(0, 100)));
    c.rise_wait    = WaitW'($urandom_range(0, 7));
    c.fall_wait    = WaitW'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 15) begin
      c.temp_low  = c.temp_high;
      c.temp_high = TempW'(tl);
    end
    if ($urandom_range(0, 99) < 15) begin
      c.freq_floor   = c.freq_ceiling;
      c.freq_ceiling = FreqW'(fl);
    end
    return c;
  endfunction

  // leaves cfg_we_i high, the caller lowers it after the last write
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] junk;
    logic [CfgDataW-1:0] data;
    junk = CfgDataW'($urandom);
    data = value;
    // unused upper bits carry noise, the register keeps only its own width
    case (idx)
      CFG_TEMP_LOW: begin
        data[CfgDataW-1:TempW] = junk[CfgDataW-1:TempW];
        gov_cfg.temp_low = value[TempW-1:0];
      end
      CFG_TEMP_HIGH: begin
        data[CfgDataW-1:TempW] = junk[CfgDataW-1:TempW];
        gov_cfg.temp_high = value[TempW-1:0];
      end
      CFG_FREQ_FLOOR:   gov_cfg.freq_floor   = value[FreqW-1:0];
      CFG_FREQ_CEILING: gov_cfg.freq_ceiling = value[FreqW-1:0];
      CFG_VOLT_LOW:     gov_cfg.volt_low     = value[VoltW-1:0];
      CFG_VOLT_HIGH:    gov_cfg.volt_high    = value[VoltW-1:0];
      CFG_RISE_WAIT: begin
        data[CfgDataW-1:WaitW] = junk[CfgDataW-1:WaitW];
        gov_cfg.rise_wait = value[WaitW-1:0];
      end
      default: begin
        data[CfgDataW-1:WaitW] = junk[CfgDataW-1:WaitW];
        gov_cfg.fall_wait = value[WaitW-1:0];
      end
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_TEMP_LOW,     CfgDataW'(c.temp_low));
    write_reg(CFG_TEMP_HIGH,    CfgDataW'(c.temp_high));
    write_reg(CFG_FREQ_FLOOR,   CfgDataW'(c.freq_floor));
    write_reg(CFG_FREQ_CEILING, CfgDataW'(c.freq_ceiling));
    write_reg(CFG_VOLT_LOW,     CfgDataW'(c.volt_low));
    write_reg(CFG_VOLT_HIGH,    CfgDataW'(c.volt_high));
    write_reg(CFG_RISE_WAIT,    CfgDataW'(c.rise_wait));
    write_reg(CFG_FALL_WAIT,    CfgDataW'(c.fall_wait));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic send_tick(input in_item_t it);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(it);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(governor_step(it));
    n_ticks++;
  endtask

  // block is idle once every tick has its result and the pipeline has emptied
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_directed();
    in_item_t seq[$];
    // first reading of zero, power off, then a held hot reading at reset settings
    seq = '{tick_of(1, 0, 1023), tick_of(0, 255, 0), tick_of(1, 70, 600),
            tick_of(1, 70, 600), tick_of(1, 70, 600), tick_of(1, 70, 600)};
    foreach (seq[i]) send_tick(seq[i]);
    drain();
    write_reg(CFG_RISE_WAIT, '0);
    write_reg(CFG_FALL_WAIT, '0);
    write_reg(CFG_FREQ_FLOOR, CfgDataW'(240));
    cfg_we_i <= 1'b0;
    // hot steps down to the floor, too-hot under power off, cool steps, the
    // middle band, then a sag through the voltage schedule and recovery
    seq = '{tick_of(1, 255, 1023), tick_of(1, 255, 1023), tick_of(1, 255, 1023),
            tick_of(0, 255, 0), tick_of(0, 60, 5), tick_of(0, 59, 1023),
            tick_of(1, 0, 1023), tick_of(1, 59, 1023), tick_of(1, 59, 1023),
            tick_of(1, 62, 1023), tick_of(1, 62, 449),
            tick_of(1, 62, 0), tick_of(1, 62, 0), tick_of(1, 62, 0),
            tick_of(1, 62, 455), tick_of(1, 62, 455),
            tick_of(1, 62, 461), tick_of(1, 62, 461), tick_of(1, 62, 1023)};
    foreach (seq[i]) send_tick(seq[i]);
    drain();
  endtask

  task automatic test_odd_settings();
    cfg_t odd[4];
    odd[0] = '0;
    odd[1] = '1;
    odd[2] = '{temp_low: 200, temp_high: 30, freq_floor: 900, freq_ceiling: 200,
               volt_low: 600, volt_high: 300, rise_wait: 0, fall_wait: 7};
    odd[3] = '{temp_low: 255, temp_high: 0, freq_floor: 1023, freq_ceiling: 0,
               volt_low: 1, volt_high: 1022, rise_wait: 7, fall_wait: 0};
    foreach (odd[k]) begin
      apply_settings(odd[k]);
      repeat (60) send_tick(random_tick());
      drain();
    end
  endtask

  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct);
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    repeat (5) begin
      apply_settings(pick_settings());
      repeat (80) send_tick(random_tick());
      drain();
    end
  endtask

  // result checking, receiver stalls and watchdog
  always @(posedge clk_i) begin : check_results
    result_t want;
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no tick pending: freq_target %0d",
               m_axis_tdata[FreqW-1:0]);
        failures++;
      end else begin
        want = expected_results.pop_front();
        n_results++;
        if (m_axis_tdata[FreqW-1:0] !== want.freq_target) begin
          $error("freq_target mismatch: expected %0d, actual %0d",
                 want.freq_target, m_axis_tdata[FreqW-1:0]);
          failures++;
        end
        if (m_axis_tdata[FreqW] !== want.too_hot) begin
          $error("too_hot mismatch: expected %0d, actual %0d",
                 want.too_hot, m_axis_tdata[FreqW]);
          failures++;
        end
        if (m_axis_tdata[FreqW+1] !== want.volt_mode) begin
          $error("volt_mode mismatch: expected %0d, actual %0d",
                 want.volt_mode, m_axis_tdata[FreqW+1]);
          failures++;
        end
      end
    end
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("thermal_voltage_freq_governor_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_gap_pct    = 21;
    sink_stall_pct = 69;
    test_directed();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_odd_settings();
    test_random_traffic(21, 69);
    test_random_traffic(69, 21);
    test_random_traffic(0, 0);
    drain();
    $display("covered %0d ticks and %0d checked results over %0d register settings,",
             n_ticks, n_results, n_settings);
    $display("including swapped limits, all-zero and all-one settings and sag episodes");
    if (failures == 0) begin
      $display("thermal_voltage_freq_governor_top test passed");
    end else begin
      $display("thermal_voltage_freq_governor_top test failed");
    end
    $finish;
  end

endmodule
